// ----- hw/rtl/bb3_pkg.sv -----
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int CH_W     = 8;
	localparam int NUM_CH   = 3;
	localparam int PIX_W    = CH_W * NUM_CH;
	localparam int POS_W    = 10;
	localparam int SIZE_W   = 11;
	localparam int CS_W     = 10;
	localparam int SUM_W    = 12;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int MIN_SIZE = 3;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd800;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd600;

	// register index is paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// floor(x / 9) for x < 2304 as (x * 3641) >> 15
	localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
	localparam int               DIV9_SHIFT = 15;

	typedef struct packed {
		logic [PIX_W-1:0] in_color;
		logic             frame_start;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_color;
		logic [POS_W-1:0] out_col;
		logic [POS_W-1:0] out_row;
		logic             frame_end;
	} out_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] frame_width;
		logic [SIZE_W-1:0] frame_height;
	} cfg_t;

	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
		logic [2*SUM_W-1:0] prod;
		prod = x * DIV9_MUL;
		return prod[DIV9_SHIFT +: CH_W];
	endfunction

endpackage

// ----- hw/rtl/bb3_line_mem.sv -----
// ----------------------------------------------------------------------------
// bb3_line_mem
// Line store: one word per column holding the upper and middle rows.
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module bb3_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/bb3_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bb3_cfg_regs
// APB register file: frame width and frame height.
// ----------------------------------------------------------------------------
module bb3_cfg_regs import bb3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = DATA_W'(width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.frame_width  = width_q;
	assign cfg.frame_height = height_q;

endmodule

// ----- hw/rtl/box_blur_3x3_rgb_core.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box blur of packed RGB pixels in raster order.
// Throughput: one pixel per clock unless dst_stall backs up the output,
// set by the single-port-pair line store (one read and one write per
// pixel, same-column reuse forwarded).
// Reset: counters, window and valids clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core import bb3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              src_valid,
	output logic              src_stall,
	input  in_item_t          src_item,
	output logic              dst_valid,
	input  logic              dst_stall,
	output out_item_t         dst_item
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WB = CW + 1;
	localparam int HB = RW + 1;
	localparam int MW = 2 * PIX_W;

	cfg_t cfg;

	bb3_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective frame size
	logic [WB-1:0] w_eff;
	logic [HB-1:0] h_eff;

	always_comb begin
		if (cfg.frame_width < SIZE_W'(MIN_SIZE)) begin
			w_eff = WB'(MIN_SIZE);
		end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(cfg.frame_width);
		end
		if (cfg.frame_height < SIZE_W'(MIN_SIZE)) begin
			h_eff = HB'(MIN_SIZE);
		end else if (int'(cfg.frame_height) > MAX_HEIGHT) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(cfg.frame_height);
		end
	end

	// pipeline control
	logic acc;
	logic s1_valid_s1;
	logic s1_go;
	logic s2_valid_s2;
	logic s2_go;
	logic s2_free;
	logic res_s1;
	logic dst_valid_q;

	assign s2_go     = s2_valid_s2 && (!dst_valid_q || !dst_stall);
	assign s2_free   = !s2_valid_s2 || s2_go;
	assign s1_go     = s1_valid_s1 && (!res_s1 || s2_free);
	assign src_stall = s1_valid_s1 && !s1_go;
	assign acc       = src_valid && !src_stall;

	// stage 0: position
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [CW-1:0]    c0;
	logic [RW-1:0]    r0;
	logic [CW-1:0]    cm1;
	logic [RW-1:0]    rm1;
	logic             res0;
	logic             end0;
	logic             col_wrap;

	assign c0  = src_item.frame_start ? '0 : col_q;
	assign r0  = src_item.frame_start ? '0 : row_q;
	assign cm1 = c0 - CW'(1);
	assign rm1 = r0 - RW'(1);

	assign res0 = ({1'b0, c0} >= WB'(2)) && ({1'b0, r0} >= HB'(2))
		&& ({1'b0, c0} < w_eff) && ({1'b0, r0} < h_eff);
	assign end0 = ({1'b0, c0} == w_eff - WB'(1)) && ({1'b0, r0} == h_eff - HB'(1));
	assign col_wrap = ({1'b0, c0} + WB'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (({1'b0, r0} + HB'(1)) >= h_eff) ? '0 : r0 + RW'(1);
			end else begin
				col_q <= c0 + CW'(1);
				row_q <= r0;
			end
		end
	end

	// stage 1: line store read, forwarding, column sums
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [POS_W-1:0] oc_s1;
	logic [POS_W-1:0] or_s1;
	logic             end_s1;
	logic             fwd_s1;
	logic [MW-1:0]    fwd_data_s1;
	logic [MW-1:0]    rd_data;
	logic [MW-1:0]    line_word;
	logic [PIX_W-1:0] up_px;
	logic [PIX_W-1:0] mid_px;

	assign line_word = fwd_s1 ? fwd_data_s1 : rd_data;
	assign up_px     = line_word[MW-1:PIX_W];
	assign mid_px    = line_word[PIX_W-1:0];

	bb3_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW),
		.DW    (MW)
	) u_lines (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata ({mid_px, pix_s1}),
		.re    (acc),
		.raddr (c0),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (acc) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1      <= c0;
			pix_s1      <= src_item.in_color;
			res_s1      <= res0;
			oc_s1       <= POS_W'(cm1);
			or_s1       <= POS_W'(rm1);
			end_s1      <= end0;
			fwd_s1      <= s1_valid_s1 && (col_s1 == c0);
			fwd_data_s1 <= {mid_px, pix_s1};
		end
	end

	logic [NUM_CH-1:0][CS_W-1:0]  cs_cur;
	logic [NUM_CH-1:0][CS_W-1:0]  cs_old_q;
	logic [NUM_CH-1:0][CS_W-1:0]  cs_new_q;
	logic [NUM_CH-1:0][SUM_W-1:0] tot;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			cs_cur[k] = CS_W'(up_px[CH_W*k +: CH_W]) + CS_W'(mid_px[CH_W*k +: CH_W])
				+ CS_W'(pix_s1[CH_W*k +: CH_W]);
			tot[k] = SUM_W'(cs_old_q[k]) + SUM_W'(cs_new_q[k]) + SUM_W'(cs_cur[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_old_q <= '0;
			cs_new_q <= '0;
		end else if (s1_go) begin
			cs_old_q <= cs_new_q;
			cs_new_q <= cs_cur;
		end
	end

	// stage 2: channel totals
	logic [NUM_CH-1:0][SUM_W-1:0] tot_s2;
	logic [POS_W-1:0]             oc_s2;
	logic [POS_W-1:0]             or_s2;
	logic                         end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s1_go && res_s1) begin
			s2_valid_s2 <= 1'b1;
		end else if (s2_go) begin
			s2_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_s1) begin
			tot_s2 <= tot;
			oc_s2  <= oc_s1;
			or_s2  <= or_s1;
			end_s2 <= end_s1;
		end
	end

	// output register: divide by nine
	out_item_t        dst_item_q;
	logic [PIX_W-1:0] color;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			color[CH_W*k +: CH_W] = div9(tot_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (s2_go) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			dst_item_q.out_color <= color;
			dst_item_q.out_col   <= oc_s2;
			dst_item_q.out_row   <= or_s2;
			dst_item_q.frame_end <= end_s2;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

endmodule

// ----- tb/sv/box_blur_3x3_rgb_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core_tb
// Self-checking bench for the 3x3 RGB box blur core. A short directed table
// covers the borders, the value extremes, frame wrap and restart. Random
// frames then run under several frame sizes (saturated sizes included) and
// idle/stall mixes. Every output transaction is checked against a fixed
// value in the table or a behavioral blur model kept in the bench.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core_tb;
	import bb3_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 1024;
	localparam int WINDOW_AREA  = 9;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1400;
	localparam int LIMIT_NS     = 5_000_000;
	localparam int DIR_ROWS     = 25;

	localparam logic [ADDR_W-1:0] ADDR_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH} idle_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} chk_t;

	typedef struct packed {
		logic [PIX_W-1:0] color;
		logic             fs;
		chk_t             chk;
		out_item_t        fixed;
	} dir_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              src_valid = 1'b0;
	logic              src_stall;
	in_item_t          src_item  = '0;
	logic              dst_valid;
	logic              dst_stall = 1'b0;
	out_item_t         dst_item;

	idle_t     idle_mode = IDLE_NONE;
	int        err_cnt   = 0;
	out_item_t blur_q [$];

	// blur model state
	logic [PIX_W-1:0]  upper_px  [MAX_W];
	logic [PIX_W-1:0]  middle_px [MAX_W];
	bit                upper_set [MAX_W];
	bit                middle_set[MAX_W];
	logic [PIX_W-1:0]  win_px    [6];
	bit                win_set   [6];
	int unsigned       col_pos   = 0;
	int unsigned       row_pos   = 0;
	logic [SIZE_W-1:0] cfg_width  = WIDTH_RST;
	logic [SIZE_W-1:0] cfg_height = HEIGHT_RST;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{24'hFFFFFF, 1'b1, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_FIXED, '{24'hFFFFFF, 10'd1, 10'd1, 1'b1}},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'h000000, 1'b0, CHK_NONE,  '0},
		'{24'hFFFFFF, 1'b0, CHK_FIXED, '{24'h1C1C1C, 10'd1, 10'd1, 1'b1}},
		'{24'hFF0000, 1'b0, CHK_MODEL, '0},
		'{24'h00FF00, 1'b0, CHK_MODEL, '0},
		'{24'h0000FF, 1'b1, CHK_MODEL, '0},
		'{24'h800001, 1'b0, CHK_MODEL, '0},
		'{24'h7F7F7F, 1'b0, CHK_MODEL, '0},
		'{24'h010280, 1'b0, CHK_MODEL, '0},
		'{24'hFEFDFC, 1'b0, CHK_MODEL, '0}
	};

	box_blur_3x3_rgb_core #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
		if (v < MIN_SIZE)
			return MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// true when this pixel would produce a result built from a never-written line entry
	function automatic bit blur_reads_unset(input in_item_t it);
		int unsigned w, h, c, r;
		int k;
		w = eff_size(cfg_width, MAX_W);
		h = eff_size(cfg_height, MAX_H);
		c = col_pos;
		r = row_pos;
		if (it.frame_start || c < 2 || r < 2 || c >= w || r >= h)
			return 1'b0;
		for (k = 0; k < 6; k++)
			if (!win_set[k])
				return 1'b1;
		return !(upper_set[c] && middle_set[c]);
	endfunction

	function automatic bit blur_step(input in_item_t it, output out_item_t res);
		int unsigned w, h, c, r, sum;
		logic [PIX_W-1:0] cur [3];
		bit cur_set [3];
		bit hit;
		int s, k;
		w = eff_size(cfg_width, MAX_W);
		h = eff_size(cfg_height, MAX_H);
		if (it.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		cur[0] = upper_px[c];
		cur[1] = middle_px[c];
		cur[2] = it.in_color;
		cur_set[0] = upper_set[c];
		cur_set[1] = middle_set[c];
		cur_set[2] = 1'b1;
		hit = c >= 2 && r >= 2 && c < w && r < h;
		res = '0;
		if (hit) begin
			for (s = 0; s < NUM_CH; s++) begin
				sum = 0;
				for (k = 0; k < 6; k++)
					sum += win_px[k][s*CH_W +: CH_W];
				for (k = 0; k < 3; k++)
					sum += cur[k][s*CH_W +: CH_W];
				res.out_color[s*CH_W +: CH_W] = CH_W'(sum / WINDOW_AREA);
			end
			res.out_col   = POS_W'(c - 1);
			res.out_row   = POS_W'(r - 1);
			res.frame_end = (c == w - 1) && (r == h - 1);
		end
		upper_px[c]   = middle_px[c];
		upper_set[c]  = middle_set[c];
		middle_px[c]  = it.in_color;
		middle_set[c] = 1'b1;
		for (k = 0; k < 3; k++) begin
			win_px[k]      = win_px[k + 3];
			win_set[k]     = win_set[k + 3];
			win_px[k + 3]  = cur[k];
			win_set[k + 3] = cur_set[k];
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
		return hit;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] px;
		int s;
		px = PIX_W'($urandom());
		for (s = 0; s < NUM_CH; s++) begin
			case ($urandom_range(0, 9))
				0: px[s*CH_W +: CH_W] = '0;
				1: px[s*CH_W +: CH_W] = '1;
				default: ;
			endcase
		end
		return px;
	endfunction

	task automatic report(input string name, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		err_cnt++;
	endtask

	task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		logic rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy   = pready;
			rdata = prdata;
			@(posedge clk);
		end while (rdy !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] want);
		logic [DATA_W-1:0] rd;
		apb_xfer(1'b0, addr, '0, rd);
		if (rd[SIZE_W-1:0] !== want)
			report("register readback", 32'(want), 32'(rd[SIZE_W-1:0]));
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		logic [DATA_W-1:0] wv, hv, rd;
		wv = $urandom();
		hv = $urandom();
		wv[SIZE_W-1:0] = w;
		hv[SIZE_W-1:0] = h;
		apb_xfer(1'b1, ADDR_WIDTH, wv, rd);
		cfg_width = w;
		apb_xfer(1'b1, ADDR_HEIGHT, hv, rd);
		cfg_height = h;
		check_reg(ADDR_WIDTH, w);
		check_reg(ADDR_HEIGHT, h);
	endtask

	// drop valid, let every pending result drain, then settle the pipeline
	task automatic wait_idle();
		src_valid <= 1'b0;
		while (blur_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(input in_item_t it, input chk_t chk, input out_item_t fixed);
		bit acc, hit;
		out_item_t res;
		while ((idle_mode == IDLE_SRC && chance(67)) || (idle_mode == IDLE_BOTH && chance(24))) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do begin
			@(negedge clk);
			acc = (src_stall === 1'b0);
			@(posedge clk);
		end while (!acc);
		hit = blur_step(it, res);
		case (chk)
			CHK_MODEL: if (hit) blur_q.push_back(res);
			CHK_FIXED: blur_q.push_back(fixed);
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		dst_stall <= (idle_mode == IDLE_DST && chance(67)) ||
			(idle_mode == IDLE_BOTH && chance(24));
	end

	always @(negedge clk) begin : result_mon
		out_item_t want;
		if (arst_n && dst_valid === 1'b1 && dst_stall === 1'b0) begin
			if (blur_q.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, dst_item);
				err_cnt++;
			end else begin
				want = blur_q.pop_front();
				if (dst_item.out_color !== want.out_color)
					report("out_color", 32'(want.out_color), 32'(dst_item.out_color));
				if (dst_item.out_col !== want.out_col)
					report("out_col", 32'(want.out_col), 32'(dst_item.out_col));
				if (dst_item.out_row !== want.out_row)
					report("out_row", 32'(want.out_row), 32'(dst_item.out_row));
				if (dst_item.frame_end !== want.frame_end)
					report("frame_end", 32'(want.frame_end), 32'(dst_item.frame_end));
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	initial begin : stim
		in_item_t it;
		logic [SIZE_W-1:0] w, h;
		int n, i, ph, small_ph, random_done;
		idle_t mode;
		bit fresh;

		foreach (win_px[k]) begin
			win_px[k]  = '0;
			win_set[k] = 1'b1;
		end
		foreach (upper_set[k]) begin
			upper_px[k]   = '0;
			middle_px[k]  = '0;
			upper_set[k]  = 1'b0;
			middle_set[k] = 1'b0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reg(ADDR_WIDTH, WIDTH_RST);
		check_reg(ADDR_HEIGHT, HEIGHT_RST);

		// both sizes below the minimum, so the core runs 3x3
		set_size(11'd0, 11'd2);
		for (i = 0; i < DIR_ROWS; i++) begin
			it.in_color    = dir_rows[i].color;
			it.frame_start = dir_rows[i].fs;
			send_pixel(it, dir_rows[i].chk, dir_rows[i].fixed);
		end

		ph = 0;
		small_ph = 0;
		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			fresh = 1'b1;
			if (ph == 1) begin
				// saturated width: run past the column wrap at the maximum
				w = 11'd2047;
				h = 11'd0;
				n = MAX_W + 4;
				mode = IDLE_NONE;
			end else if (ph == 3) begin
				w = 11'd3;
				h = 11'd2047;
				n = 3 * 20;
				mode = IDLE_NONE;
			end else begin
				w = SIZE_W'(chance(15) ? $urandom_range(0, 2) : $urandom_range(3, 14));
				h = SIZE_W'(chance(15) ? $urandom_range(0, 2) : $urandom_range(3, 9));
				n = $urandom_range(40, 80);
				mode = idle_t'(small_ph % 4);
				fresh = chance(75);
				small_ph++;
			end
			random_done += n;
			wait_idle();
			set_size(w, h);
			idle_mode = mode;
			for (i = 0; i < n; i++) begin
				it.in_color    = rand_pixel();
				it.frame_start = (i == 0 && fresh) || $urandom_range(0, 149) == 0;
				// a grown width must not pull in line entries never written
				if (blur_reads_unset(it))
					it.frame_start = 1'b1;
				send_pixel(it, CHK_MODEL, '0);
			end
			ph++;
		end

		wait_idle();
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_line_mem.sv
hw/rtl/bb3_cfg_regs.sv
hw/rtl/box_blur_3x3_rgb_core.sv
tb/sv/box_blur_3x3_rgb_core_tb.sv
